// ===== hdl/ggc_pkg.sv =====
`default_nettype none

package ggc_pkg;

  localparam int unsigned MaxVertices = 256;
  localparam int unsigned VtxAddrW    = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned VtxCntW     = $clog2(MaxVertices + 1);
  localparam int unsigned ColourW     = 8;
  localparam int unsigned NumColours  = 1 << ColourW;
  localparam int unsigned NbW         = 8;

  typedef logic [ColourW-1:0]    colour_t;
  typedef logic [VtxCntW-1:0]    vtx_cnt_t;
  typedef logic [VtxAddrW-1:0]   vtx_addr_t;
  typedef logic [NumColours-1:0] colour_set_t;

  typedef struct packed {
    logic           new_graph;
    logic           has_neighbour;
    logic [NbW-1:0] neighbour;
    logic           last_neighbour;
  } in_item_t;

  typedef struct packed {
    logic [7:0] vertex;
    colour_t    colour;
    logic       overflow;
  } out_item_t;

  // controls from the pipeline to the taken-colour unit
  typedef struct packed {
    logic    go;
    logic    restart;
    logic    set_en;
    colour_t set_colour;
    logic    last;
  } taken_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/ggc_ram.sv =====
`default_nettype none

module ggc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ggc_taken.sv =====
`default_nettype none

module ggc_taken (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ggc_pkg::taken_ctl_t ctl_i,
  output ggc_pkg::colour_t         free_colour_o
);

  localparam int unsigned GroupW    = 16;
  localparam int unsigned NumGroups = ggc_pkg::NumColours / GroupW;
  localparam int unsigned GrpSelW   = $clog2(NumGroups);
  localparam int unsigned BitSelW   = $clog2(GroupW);

  ggc_pkg::colour_set_t taken_q, taken_d;
  ggc_pkg::colour_set_t merged;
  logic [NumGroups-1:0] grp_free;
  logic [GroupW-1:0]    grp_bits;
  logic [GrpSelW-1:0]   grp_sel;
  logic [BitSelW-1:0]   bit_sel;

  always_comb begin
    merged = ctl_i.restart ? '0 : taken_q;
    if (ctl_i.set_en) begin
      merged[ctl_i.set_colour] = 1'b1;
    end
  end

  // two-level first-zero search: pick the lowest group with a free colour, then the bit
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_free[g] = ~&merged[g*GroupW +: GroupW];
    end
    grp_sel = '0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      if (grp_free[g]) grp_sel = GrpSelW'(g);
    end
    grp_bits = merged[grp_sel*GroupW +: GroupW];
    bit_sel  = '0;
    for (int i = GroupW - 1; i >= 0; i--) begin
      if (!grp_bits[i]) bit_sel = BitSelW'(i);
    end
    // all colours taken saturates at the top colour
    free_colour_o = (|grp_free) ? {grp_sel, bit_sel} : '1;
  end

  always_comb begin
    taken_d = taken_q;
    if (ctl_i.go) begin
      taken_d = ctl_i.last ? '0 : merged;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
    end else begin
      taken_q <= taken_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/greedy_graph_colouring.sv =====
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o | in_data_i  (ggc_pkg::in_item_t)
// out     | output    | out_valid_o/out_ready_i | out_data_o (ggc_pkg::out_item_t)
//
// one list entry per cycle unless a last entry waits on a full output: stage 0 reads the
// colour memory at the neighbour, stage 1 merges that colour into the taken set and, on
// the last entry, picks the first free colour and writes it back unless overflowed.
// the rate is set by the single read and write port of the colour memory.
// coloured marks are a fill count (vertices below the current one), so reset
// needs no clearing pass; the colour memory itself is never cleared.
// a stalled output holds one result plus one last entry in stage 1.
`default_nettype none

module greedy_graph_colouring (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ggc_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ggc_pkg::out_item_t     out_data_o
);

  logic                accept;
  ggc_pkg::vtx_cnt_t   cur_q, cur_d, cur_eff;
  logic                nb_coloured, over0;
  ggc_pkg::vtx_addr_t  rd_addr, wr_addr;
  ggc_pkg::colour_t    rd_data, free_colour, s1_colour;
  logic                wr_en, fwd_d;

  logic                s1_valid_q, s1_valid_d;
  logic                s1_coloured_q, s1_new_q, s1_last_q, s1_over_q, s1_fwd_q;
  ggc_pkg::vtx_cnt_t   s1_vertex_q;
  ggc_pkg::colour_t    fwd_colour_q;
  logic                s1_go, out_free;

  logic                out_valid_q;
  ggc_pkg::out_item_t  out_data_q;
  ggc_pkg::taken_ctl_t taken_ctl;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign accept     = in_valid_i && in_ready_o;

  // stage 0: restart, coloured test against the fill count, memory read
  always_comb begin
    cur_eff     = in_data_i.new_graph ? '0 : cur_q;
    nb_coloured = in_data_i.has_neighbour &&
                  (32'(in_data_i.neighbour) < 32'(cur_eff));
    over0       = (32'(cur_eff) >= ggc_pkg::MaxVertices);
    rd_addr     = ggc_pkg::VtxAddrW'(in_data_i.neighbour);
    cur_d       = cur_q;
    if (accept) begin
      cur_d = cur_eff;
      if (in_data_i.last_neighbour && !over0) begin
        cur_d = cur_eff + ggc_pkg::vtx_cnt_t'(1);
      end
    end
  end

  // stage 1 write-back
  assign wr_en   = s1_go && s1_last_q && !s1_over_q;
  assign wr_addr = ggc_pkg::VtxAddrW'(s1_vertex_q);
  // read of an entry being written in the same cycle returns stale data
  assign fwd_d   = wr_en && (wr_addr == rd_addr);

  ggc_ram #(
    .Width (ggc_pkg::ColourW),
    .Depth (ggc_pkg::MaxVertices)
  ) u_colour_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (free_colour),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign s1_colour = s1_fwd_q ? fwd_colour_q : rd_data;

  always_comb begin
    taken_ctl.go         = s1_go;
    taken_ctl.restart    = s1_new_q;
    taken_ctl.set_en     = s1_coloured_q;
    taken_ctl.set_colour = s1_colour;
    taken_ctl.last       = s1_last_q;
  end

  ggc_taken u_taken (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (taken_ctl),
    .free_colour_o (free_colour)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q         <= '0;
      s1_valid_q    <= 1'b0;
      s1_coloured_q <= 1'b0;
      s1_new_q      <= 1'b0;
      s1_last_q     <= 1'b0;
      s1_over_q     <= 1'b0;
      s1_fwd_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      cur_q      <= cur_d;
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        s1_coloured_q <= nb_coloured;
        s1_new_q      <= in_data_i.new_graph;
        s1_last_q     <= in_data_i.last_neighbour;
        s1_over_q     <= over0;
        s1_fwd_q      <= fwd_d;
      end
      if (s1_go && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_vertex_q  <= cur_eff;
      fwd_colour_q <= free_colour;
    end
    if (s1_go && s1_last_q) begin
      out_data_q.vertex   <= 8'(s1_vertex_q);
      out_data_q.colour   <= free_colour;
      out_data_q.overflow <= s1_over_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/ggc_checker.sv =====
`default_nettype none

module ggc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire ggc_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire ggc_pkg::out_item_t out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // an overflow result names the saturated vertex count, truncated to eight bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |->
      out_data_o.vertex == 8'(ggc_pkg::MaxVertices))
    else $error("overflow with wrong vertex");

  // no result is presented while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // with the output register empty the pipeline can always take a transfer
  assert property (@(posedge clk_i) !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind greedy_graph_colouring ggc_checker u_ggc_checker (.*);

`default_nettype wire
